/* rtl/beam_second_moment_width_macros.svh */
// ----------------------------------------------------------------------------
// Beam width assertion macros
// Shared concurrent assertion forms for the beam width block.
// ----------------------------------------------------------------------------
`ifndef BEAM_SECOND_MOMENT_WIDTH_MACROS_SVH
`define BEAM_SECOND_MOMENT_WIDTH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSMW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSMW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bsmw_pkg.sv */
// ----------------------------------------------------------------------------
// Beam width package
// Types, step codes and limits shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package bsmw_pkg;

	typedef logic [127:0] wide_t;
	typedef logic [4:0] step_t;

	localparam step_t STP_MXX  = 5'd0;
	localparam step_t STP_MXX2 = 5'd1;
	localparam step_t STP_MYY  = 5'd2;
	localparam step_t STP_MYY2 = 5'd3;
	localparam step_t STP_MXY  = 5'd4;
	localparam step_t STP_MXY2 = 5'd5;
	localparam step_t STP_MSS  = 5'd6;
	localparam step_t STP_DCX  = 5'd7;
	localparam step_t STP_DCY  = 5'd8;
	localparam step_t STP_DVX  = 5'd9;
	localparam step_t STP_DVY  = 5'd10;
	localparam step_t STP_DCV  = 5'd11;
	localparam step_t STP_DMJ  = 5'd12;
	localparam step_t STP_SMJ  = 5'd13;
	localparam step_t STP_DMN  = 5'd14;
	localparam step_t STP_SMN  = 5'd15;
	localparam step_t STP_DME  = 5'd16;
	localparam step_t STP_SME  = 5'd17;
	localparam step_t STP_LAST = STP_SME;

	localparam logic [17:0] CEN_MAX  = 18'h3FFFF;
	localparam logic [25:0] VAR_MAX  = 26'h3FFFFFF;
	localparam logic [19:0] DIAM_MAX = 20'hFFFFF;

	typedef struct packed {
		logic  busy;
		logic  start;
		step_t step;
		logic  load_out;
		logic  clear;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic s_zero;
		logic done;
		logic last_pend;
		logic out_free;
	} stat_t;

endpackage

/* rtl/bsmw_ctrl.sv */
// ----------------------------------------------------------------------------
// Beam width controller
// Steps the datapath through the end-of-frame multiply, divide and root jobs.
// ----------------------------------------------------------------------------
module bsmw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  bsmw_pkg::stat_t st,
	output bsmw_pkg::cmd_t  cmd
);
	import bsmw_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_RUN   = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q, state_d;
	step_t      step_q, step_d;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		cmd.busy     = (state_q != S_IDLE);
		cmd.start    = 1'b0;
		cmd.step     = step_q;
		cmd.load_out = 1'b0;
		cmd.clear    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (st.frame_end) begin
					step_d  = STP_MXX;
					state_d = st.s_zero ? S_FIN : S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.start = 1'b1;
				state_d   = S_RUN;
			end
			S_RUN: begin
				if (st.done) begin
					if (step_q == STP_LAST) begin
						state_d = S_FIN;
					end else begin
						step_d  = step_q + 5'd1;
						state_d = S_ISSUE;
					end
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STP_MXX;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

/* rtl/bsmw_dp.sv */
// ----------------------------------------------------------------------------
// Beam width datapath
// Moment accumulators, shift-add multiplier, restoring divider and root unit.
// ----------------------------------------------------------------------------
`include "beam_second_moment_width_macros.svh"

module bsmw_dp #(
	parameter int MAX_DIM    = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_acc,
	input  logic [9:0]            col,
	input  logic [9:0]            row,
	input  logic [PIXEL_BITS-1:0] intensity,
	input  logic                  frame_last,
	input  bsmw_pkg::cmd_t        cmd,
	output bsmw_pkg::stat_t       st,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [27:0]           total_power,
	output logic [17:0]           centroid_x,
	output logic [17:0]           centroid_y,
	output logic [25:0]           var_x,
	output logic [25:0]           var_y,
	output logic signed [26:0]    covar_xy,
	output logic [19:0]           diam_major,
	output logic [19:0]           diam_minor,
	output logic [19:0]           diam_mean,
	output logic                  empty_frame
);
	import bsmw_pkg::*;

	logic                  v_s1, last_s1, en_s1, fe_q;
	logic [9:0]            x_s1, y_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [19:0]           xx_s1, yy_s1, xy_s1;
	logic [27:0]           sum_i_q;
	logic [38:0]           sum_xi_q, sum_yi_q;
	logic [48:0]           sum_xxi_q, sum_yyi_q, sum_xyi_q;

	logic                  in_range;
	assign in_range = (13'(col) < 13'(MAX_DIM)) && (13'(row) < 13'(MAX_DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fe_q <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			fe_q <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1 <= frame_last;
			en_s1   <= in_range;
			x_s1    <= col;
			y_s1    <= row;
			pix_s1  <= intensity;
			xx_s1   <= 20'(col) * 20'(col);
			yy_s1   <= 20'(row) * 20'(row);
			xy_s1   <= 20'(col) * 20'(row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_i_q   <= '0;
			sum_xi_q  <= '0;
			sum_yi_q  <= '0;
			sum_xxi_q <= '0;
			sum_yyi_q <= '0;
			sum_xyi_q <= '0;
		end else if (cmd.clear) begin
			sum_i_q   <= '0;
			sum_xi_q  <= '0;
			sum_yi_q  <= '0;
			sum_xxi_q <= '0;
			sum_yyi_q <= '0;
			sum_xyi_q <= '0;
		end else if (v_s1 && en_s1) begin
			sum_i_q   <= sum_i_q + 28'(pix_s1);
			sum_xi_q  <= sum_xi_q + 39'(x_s1) * 39'(pix_s1);
			sum_yi_q  <= sum_yi_q + 39'(y_s1) * 39'(pix_s1);
			sum_xxi_q <= sum_xxi_q + 49'(xx_s1) * 49'(pix_s1);
			sum_yyi_q <= sum_yyi_q + 49'(yy_s1) * 49'(pix_s1);
			sum_xyi_q <= sum_xyi_q + 49'(xy_s1) * 49'(pix_s1);
		end
	end

	logic       is_mul, is_sqrt;
	logic [6:0] lim;

	always_comb begin
		is_mul  = 1'b0;
		is_sqrt = 1'b0;
		case (cmd.step) inside
			STP_MXX, STP_MXX2, STP_MYY, STP_MYY2, STP_MXY, STP_MXY2, STP_MSS: is_mul = 1'b1;
			STP_SMJ, STP_SMN, STP_SME: is_sqrt = 1'b1;
			default: ;
		endcase
		lim = is_mul ? 7'd63 : (is_sqrt ? 7'd19 : 7'd127);
	end

	logic       busy_q, done;
	logic [6:0] cnt_q;
	assign done = busy_q && (cnt_q == lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
		end
	end

	wide_t       t0_q, nx_q, ny_q, cmag_q;
	logic        neg_q, big_q;
	logic [63:0] d_q;
	logic [39:0] sq_src_q;

	wide_t nxy, two_c, num_sel, num_minor;
	logic [63:0] ma, mb, den_sel;
	assign nxy       = nx_q + ny_q;
	assign two_c     = {cmag_q[126:0], 1'b0};
	assign num_minor = (nxy < two_c) ? '0 : nxy - two_c;

	always_comb begin
		ma      = 64'(sum_i_q);
		mb      = 64'(sum_i_q);
		num_sel = {nxy[111:0], 16'd0};
		den_sel = d_q;
		case (cmd.step)
			STP_MXX:  mb = 64'(sum_xxi_q);
			STP_MXX2: begin ma = 64'(sum_xi_q); mb = 64'(sum_xi_q); end
			STP_MYY:  mb = 64'(sum_yyi_q);
			STP_MYY2: begin ma = 64'(sum_yi_q); mb = 64'(sum_yi_q); end
			STP_MXY:  mb = 64'(sum_xyi_q);
			STP_MXY2: begin ma = 64'(sum_xi_q); mb = 64'(sum_yi_q); end
			STP_DCX: begin
				num_sel = {81'd0, sum_xi_q, 8'd0};
				den_sel = 64'(sum_i_q);
			end
			STP_DCY: begin
				num_sel = {81'd0, sum_yi_q, 8'd0};
				den_sel = 64'(sum_i_q);
			end
			STP_DVX: num_sel = {nx_q[119:0], 8'd0};
			STP_DVY: num_sel = {ny_q[119:0], 8'd0};
			STP_DCV: num_sel = {cmag_q[119:0], 8'd0};
			STP_DMJ: num_sel = {(nxy[111:0] + two_c[111:0]), 16'd0};
			STP_DMN: num_sel = {num_minor[111:0], 16'd0};
			default: ;
		endcase
	end

	wide_t       mcand_q, prod_q, prod_nxt;
	logic [63:0] mplier_q;
	assign prod_nxt = mplier_q[0] ? prod_q + mcand_q : prod_q;

	wide_t       num_q, quo_q, quo_nxt;
	logic [63:0] den_q, rem_q;
	logic [64:0] rem_sh;
	logic        qbit;
	assign rem_sh  = {rem_q, num_q[127]};
	assign qbit    = rem_sh >= {1'b0, den_q};
	assign quo_nxt = {quo_q[126:0], qbit};

	logic [39:0] sv_q, sb_q;
	logic [40:0] sr_q, rb, sr_nxt;
	logic        sge;
	assign rb     = sr_q + 41'(sb_q);
	assign sge    = {1'b0, sv_q} >= rb;
	assign sr_nxt = sge ? (sr_q >> 1) + 41'(sb_q) : sr_q >> 1;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= wide_t'(ma);
			mplier_q <= mb;
			prod_q   <= '0;
			num_q    <= num_sel;
			den_q    <= den_sel;
			rem_q    <= '0;
			quo_q    <= '0;
			sv_q     <= sq_src_q;
			sr_q     <= '0;
			sb_q     <= 40'd1 << 38;
		end else if (busy_q) begin
			mcand_q  <= {mcand_q[126:0], 1'b0};
			mplier_q <= mplier_q >> 1;
			prod_q   <= prod_nxt;
			num_q    <= {num_q[126:0], 1'b0};
			rem_q    <= qbit ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
			quo_q    <= quo_nxt;
			if (sge) begin
				sv_q <= sv_q - rb[39:0];
			end
			sr_q <= sr_nxt;
			sb_q <= sb_q >> 2;
		end
	end

	logic [17:0]        cx_q, cy_q;
	logic [25:0]        vx_q, vy_q;
	logic signed [26:0] cv_q;
	logic [19:0]        dmj_q, dmn_q, dme_q;
	logic [26:0]        cov_m;
	logic [19:0]        root;

	always_comb begin
		cov_m = (quo_nxt > 128'd67108864) ? 27'd67108864 : quo_nxt[26:0];
		if (!neg_q && cov_m > 27'(VAR_MAX)) begin
			cov_m = 27'(VAR_MAX);
		end
		root = big_q ? DIAM_MAX : sr_nxt[19:0];
	end

	always_ff @(posedge clk) begin
		if (done) begin
			case (cmd.step) inside
				STP_MXX, STP_MYY, STP_MXY: t0_q <= prod_nxt;
				STP_MXX2: nx_q <= (t0_q < prod_nxt) ? '0 : t0_q - prod_nxt;
				STP_MYY2: ny_q <= (t0_q < prod_nxt) ? '0 : t0_q - prod_nxt;
				STP_MXY2: begin
					neg_q  <= t0_q < prod_nxt;
					cmag_q <= (t0_q < prod_nxt) ? prod_nxt - t0_q : t0_q - prod_nxt;
				end
				STP_MSS: d_q <= prod_nxt[63:0];
				STP_DCX: cx_q <= (quo_nxt > 128'(CEN_MAX)) ? CEN_MAX : quo_nxt[17:0];
				STP_DCY: cy_q <= (quo_nxt > 128'(CEN_MAX)) ? CEN_MAX : quo_nxt[17:0];
				STP_DVX: vx_q <= (quo_nxt > 128'(VAR_MAX)) ? VAR_MAX : quo_nxt[25:0];
				STP_DVY: vy_q <= (quo_nxt > 128'(VAR_MAX)) ? VAR_MAX : quo_nxt[25:0];
				STP_DCV: cv_q <= neg_q ? -$signed(cov_m) : $signed(cov_m);
				STP_DMJ, STP_DMN, STP_DME: begin
					big_q    <= (quo_nxt[127:37] != '0);
					sq_src_q <= {quo_nxt[36:0], 3'd0};
				end
				STP_SMJ: dmj_q <= root;
				STP_SMN: dmn_q <= root;
				STP_SME: dme_q <= root;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			empty_frame <= (sum_i_q == '0);
			total_power <= sum_i_q;
			if (sum_i_q == '0) begin
				centroid_x <= '0;
				centroid_y <= '0;
				var_x      <= '0;
				var_y      <= '0;
				covar_xy   <= '0;
				diam_major <= '0;
				diam_minor <= '0;
				diam_mean  <= '0;
			end else begin
				centroid_x <= cx_q;
				centroid_y <= cy_q;
				var_x      <= vx_q;
				var_y      <= vy_q;
				covar_xy   <= cv_q;
				diam_major <= dmj_q;
				diam_minor <= dmn_q;
				diam_mean  <= dme_q;
			end
		end
	end

	assign st.frame_end = fe_q;
	assign st.s_zero    = (sum_i_q == '0);
	assign st.done      = done;
	assign st.last_pend = (v_s1 && last_s1) || fe_q;
	assign st.out_free  = !out_valid || !out_stall;

	`BSMW_ASSERT_SAME(a_start_idle, cmd.start, !busy_q, "job started while unit busy")
	`BSMW_ASSERT_NEXT(a_clear_sum, cmd.clear, sum_i_q == '0, "accumulators not cleared")
	`BSMW_ASSERT_NEXT(a_empty_flag, cmd.load_out && (sum_i_q == '0),
		empty_frame && out_valid && (diam_major == '0), "empty frame word wrong")

endmodule

/* rtl/beam_second_moment_width.sv */
// ----------------------------------------------------------------------------
// Second-moment beam width
// Pixels enter one per cycle while in_stall is low; the last pixel of a frame stalls the input
// while the multiply, divide and root jobs run (an empty frame skips them) and while a
// result word is held. Reset clears all sums and the output valid flag.
// ----------------------------------------------------------------------------
module beam_second_moment_width #(
	parameter int MAX_DIM    = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [9:0]            col,
	input  logic [9:0]            row,
	input  logic [PIXEL_BITS-1:0] intensity,
	input  logic                  frame_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [27:0]           total_power,
	output logic [17:0]           centroid_x,
	output logic [17:0]           centroid_y,
	output logic [25:0]           var_x,
	output logic [25:0]           var_y,
	output logic signed [26:0]    covar_xy,
	output logic [19:0]           diam_major,
	output logic [19:0]           diam_minor,
	output logic [19:0]           diam_mean,
	output logic                  empty_frame
);
	import bsmw_pkg::*;

	cmd_t  cmd;
	stat_t st;

	assign in_stall = cmd.busy || st.last_pend;

	bsmw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	bsmw_dp #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_valid && !in_stall),
		.col         (col),
		.row         (row),
		.intensity   (intensity),
		.frame_last  (frame_last),
		.cmd         (cmd),
		.st          (st),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.total_power (total_power),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.var_x       (var_x),
		.var_y       (var_y),
		.covar_xy    (covar_xy),
		.diam_major  (diam_major),
		.diam_minor  (diam_minor),
		.diam_mean   (diam_mean),
		.empty_frame (empty_frame)
	);

endmodule

/* bench/beam_second_moment_width_tb.sv */
// ----------------------------------------------------------------------------
// Second-moment beam width testbench
// Streams pixel frames into the block, predicts each frame's moments, centroid,
// variances, covariance and diameters, and checks every result word in order.
// ----------------------------------------------------------------------------
module beam_second_moment_width_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsmw_pkg::*;

	typedef struct packed {
		logic [27:0] total_power;
		logic [17:0] centroid_x;
		logic [17:0] centroid_y;
		logic [25:0] var_x;
		logic [25:0] var_y;
		logic [26:0] covar_xy;
		logic [19:0] diam_major;
		logic [19:0] diam_minor;
		logic [19:0] diam_mean;
		logic        empty_frame;
	} beam_res_t;

	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
		logic [7:0] intensity;
		logic       frame_last;
		logic       typed;
		beam_res_t  res;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] col = '0;
	logic [9:0] row = '0;
	logic [7:0] intensity = '0;
	logic frame_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [27:0] total_power;
	logic [17:0] centroid_x, centroid_y;
	logic [25:0] var_x, var_y;
	logic signed [26:0] covar_xy;
	logic [19:0] diam_major, diam_minor, diam_mean;
	logic empty_frame;

	logic [27:0] acc_i;
	logic [38:0] acc_xi, acc_yi;
	logic [48:0] acc_xxi, acc_yyi, acc_xyi;
	beam_res_t frame_results[$];
	pixel_row_t dir_tab[$];
	int errors = 0;
	int n_res = 0;
	int snd_idle = 25;
	int rcv_idle = 48;
	int hold = 0;
	bit hold_done = 0;

	beam_second_moment_width u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] quot_sat(wide_t n, wide_t d, logic [63:0] cap);
		wide_t q;
		q = n / d;
		return (q > wide_t'(cap)) ? cap : q[63:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [19:0] beam_diam(wide_t t, wide_t d);
		logic [63:0] a, r;
		a = quot_sat(t << 16, d, 64'd1 << 37);
		if (a >= (64'd1 << 37)) return DIAM_MAX;
		r = floor_sqrt(a << 3);
		return (r > 64'(DIAM_MAX)) ? DIAM_MAX : r[19:0];
	endfunction

	function automatic wide_t diff_clamp(wide_t a, wide_t b);
		return (a < b) ? '0 : a - b;
	endfunction

	function automatic beam_res_t frame_moments();
		beam_res_t r;
		wide_t s, d, nx, ny, cp, cn, cmag, t, two_c;
		logic [63:0] m;
		logic neg;
		r = '0;
		s = wide_t'(acc_i);
		if (s == 0) begin
			r.empty_frame = 1'b1;
			return r;
		end
		d = s * s;
		r.total_power = acc_i;
		r.centroid_x = 18'(quot_sat(wide_t'(acc_xi) << 8, s, 64'(CEN_MAX)));
		r.centroid_y = 18'(quot_sat(wide_t'(acc_yi) << 8, s, 64'(CEN_MAX)));
		nx = diff_clamp(s * wide_t'(acc_xxi), wide_t'(acc_xi) * wide_t'(acc_xi));
		ny = diff_clamp(s * wide_t'(acc_yyi), wide_t'(acc_yi) * wide_t'(acc_yi));
		r.var_x = 26'(quot_sat(nx << 8, d, 64'(VAR_MAX)));
		r.var_y = 26'(quot_sat(ny << 8, d, 64'(VAR_MAX)));
		cp = s * wide_t'(acc_xyi);
		cn = wide_t'(acc_xi) * wide_t'(acc_yi);
		neg = cp < cn;
		cmag = neg ? cn - cp : cp - cn;
		m = quot_sat(cmag << 8, d, 64'(VAR_MAX) + 64'd1);
		if (!neg && m > 64'(VAR_MAX)) m = 64'(VAR_MAX);
		r.covar_xy = neg ? 27'(-m) : 27'(m);
		t = nx + ny;
		two_c = cmag << 1;
		r.diam_major = beam_diam(t + two_c, d);
		r.diam_minor = beam_diam(diff_clamp(t, two_c), d);
		r.diam_mean = beam_diam(t, d);
		return r;
	endfunction

	task automatic absorb_pixel(pixel_row_t p);
		logic [63:0] x, y, v;
		beam_res_t r;
		x = 64'(p.col);
		y = 64'(p.row);
		v = 64'(p.intensity);
		acc_i = acc_i + 28'(v);
		acc_xi = acc_xi + 39'(x * v);
		acc_yi = acc_yi + 39'(y * v);
		acc_xxi = acc_xxi + 49'(x * x * v);
		acc_yyi = acc_yyi + 49'(y * y * v);
		acc_xyi = acc_xyi + 49'(x * y * v);
		if (p.frame_last) begin
			r = frame_moments();
			frame_results.insert(frame_results.size(), p.typed ? p.res : r);
			acc_i = '0;
			acc_xi = '0;
			acc_yi = '0;
			acc_xxi = '0;
			acc_yyi = '0;
			acc_xyi = '0;
		end
	endtask

	task automatic send_pixel(pixel_row_t p);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		col <= p.col;
		row <= p.row;
		intensity <= p.intensity;
		frame_last <= p.frame_last;
		do @(posedge clk); while (in_stall);
		absorb_pixel(p);
		@(negedge clk);
	endtask

	function automatic pixel_row_t px(int c, int r, int v, bit last);
		pixel_row_t p;
		p = '0;
		p.col = 10'(c);
		p.row = 10'(r);
		p.intensity = 8'(v);
		p.frame_last = last;
		return p;
	endfunction

	function automatic pixel_row_t px_typed(int c, int r, int v, beam_res_t res);
		pixel_row_t p;
		p = px(c, r, v, 1'b1);
		p.typed = 1'b1;
		p.res = res;
		return p;
	endfunction

	task automatic tab_add(pixel_row_t p);
		dir_tab.insert(dir_tab.size(), p);
	endtask

	task automatic chk(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h, got %0h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		if (hold > 0) begin
			hold--;
			out_stall <= 1'b1;
		end else if (!hold_done && n_res >= 8) begin
			hold_done = 1;
			hold = 5000;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	always @(posedge clk) begin
		beam_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_res++;
			if (frame_results.size() == 0) begin
				$display("%0t: result word with no frame pending", $realtime);
				errors++;
			end else begin
				e = frame_results.pop_front();
				chk("total_power", 64'(e.total_power), 64'(total_power));
				chk("centroid_x", 64'(e.centroid_x), 64'(centroid_x));
				chk("centroid_y", 64'(e.centroid_y), 64'(centroid_y));
				chk("var_x", 64'(e.var_x), 64'(var_x));
				chk("var_y", 64'(e.var_y), 64'(var_y));
				chk("covar_xy", 64'(e.covar_xy), 64'($unsigned(covar_xy)));
				chk("diam_major", 64'(e.diam_major), 64'(diam_major));
				chk("diam_minor", 64'(e.diam_minor), 64'(diam_minor));
				chk("diam_mean", 64'(e.diam_mean), 64'(diam_mean));
				chk("empty_frame", 64'(e.empty_frame), 64'(empty_frame));
			end
		end
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		beam_res_t er;
		int items, len, cx, cy, spread, kind;
		acc_i = '0;
		acc_xi = '0;
		acc_yi = '0;
		acc_xxi = '0;
		acc_yyi = '0;
		acc_xyi = '0;
		er = '0;
		er.empty_frame = 1'b1;
		tab_add(px_typed(0, 0, 0, er));
		tab_add(px(1023, 1023, 0, 0));
		tab_add(px_typed(5, 7, 0, er));
		er = '0;
		er.total_power = 1;
		tab_add(px_typed(0, 0, 1, er));
		er.total_power = 255;
		er.centroid_x = 261888;
		er.centroid_y = 261888;
		tab_add(px_typed(1023, 1023, 255, er));
		tab_add(px(0, 0, 255, 0));
		tab_add(px(1023, 1023, 255, 1));
		tab_add(px(0, 1023, 255, 0));
		tab_add(px(1023, 0, 255, 1));
		tab_add(px(0, 512, 200, 0));
		tab_add(px(1023, 512, 200, 1));
		tab_add(px(512, 500, 10, 0));
		tab_add(px(513, 501, 20, 0));
		tab_add(px(511, 499, 30, 0));
		tab_add(px(512, 0, 0, 0));
		tab_add(px(512, 502, 255, 1));
		tab_add(px(682, 341, 170, 0));
		tab_add(px(341, 682, 85, 1));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) send_pixel(dir_tab[i]);

		items = 0;
		while (items < 400) begin
			if (items >= 260) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (items >= 130) begin
				snd_idle = 48;
				rcv_idle = 25;
			end
			len = $urandom_range(1, 10);
			kind = $urandom_range(9);
			cx = $urandom_range(1023);
			cy = $urandom_range(1023);
			spread = $urandom_range(1, 40);
			for (int k = 0; k < len; k++) begin
				pixel_row_t p;
				if (kind == 0) begin
					p = px($urandom_range(1023), $urandom_range(1023), 0, k == len - 1);
				end else if (kind <= 2) begin
					p = px($urandom_range(1023), $urandom_range(1023),
						$urandom_range(255), k == len - 1);
				end else begin
					p = px((cx + $urandom_range(spread)) % 1024,
						(cy + $urandom_range(spread)) % 1024,
						(kind == 3) ? 255 : $urandom_range(255), k == len - 1);
				end
				send_pixel(p);
				items++;
			end
		end
		in_valid <= 1'b0;

		while (frame_results.size() > 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/bsmw_pkg.sv
rtl/bsmw_ctrl.sv
rtl/bsmw_dp.sv
rtl/beam_second_moment_width.sv
bench/beam_second_moment_width_tb.sv
